@@ rtl/b32d_pkg.sv @@
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, character codes and helper functions of the Base32 decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

    localparam int GROUP_W    = 40;
    localparam int CHARS_W    = 4;
    localparam int POS_W      = 3;
    localparam int BYTES_W    = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD    = 8'h3D;  // '='
    localparam logic [7:0] CHAR_UPPER_A = 8'h41; // 'A'
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A; // 'Z'
    localparam logic [7:0] CHAR_DIGIT_2 = 8'h32; // '2'
    localparam logic [7:0] CHAR_DIGIT_7 = 8'h37; // '7'
    localparam logic [7:0] DIGIT_BASE   = 8'd26;

    localparam logic [POS_W-1:0]   LAST_POS   = 3'd7;
    localparam logic [CHARS_W-1:0] FULL_CHARS = 4'd8;
    localparam logic [BYTES_W-1:0] MAX_BYTES  = 3'd5;

    // One finished group handed from the front to the back.
    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        logic [BYTES_W-1:0] count;
        logic               err;
    } t_group;

    typedef struct packed {
        logic       ok;
        logic [4:0] value;
    } t_sym;

    function automatic t_sym decode_char(input logic [7:0] c);
        t_sym       s;
        logic [7:0] diff;
        s    = '0;
        diff = '0;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
                diff    = c - CHAR_UPPER_A;
                s.ok    = 1'b1;
                s.value = diff[4:0];
            end
            [CHAR_DIGIT_2:CHAR_DIGIT_7]: begin
                diff    = c - CHAR_DIGIT_2 + DIGIT_BASE;
                s.ok    = 1'b1;
                s.value = diff[4:0];
            end
            default: begin
                s.ok    = 1'b0;
                s.value = 5'd0;
            end
        endcase
        return s;
    endfunction

    // Output bytes for a number of data characters; zero means bad padding.
    function automatic logic [BYTES_W-1:0] bytes_for_count(input logic [CHARS_W-1:0] n);
        logic [BYTES_W-1:0] r;
        case (n)
            4'd2:    r = 3'd1;
            4'd4:    r = 3'd2;
            4'd5:    r = 3'd3;
            4'd7:    r = 3'd4;
            4'd8:    r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/b32d_front.sv @@
// ----------------------------------------------------------------------------
// b32d_front
// Accepts characters, builds the 40-bit group and its padding status, and
// pushes one finished group record into the queue after every eighth character.
// ----------------------------------------------------------------------------
module b32d_front
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_full,
    output logic       o_push,
    output t_group     o_group
);

    logic [GROUP_W-1:0] r_bits, n_bits;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [CHARS_W-1:0] r_chars, n_chars;
    logic               r_pad, n_pad;
    logic               r_err, n_err;
    logic               r_late, n_late;

    logic               accept;
    logic               is_pad;
    t_sym               sym;
    logic [BYTES_W-1:0] tbl_count;

    // Only the closing character of a group needs room in the queue.
    assign o_stall = (r_pos == LAST_POS) && i_full;
    assign accept  = i_valid && !o_stall;
    assign is_pad  = (i_char_code == CHAR_PAD);
    assign sym     = decode_char(i_char_code);

    always_comb begin
        n_bits  = {r_bits[GROUP_W-6:0], is_pad ? 5'd0 : sym.value};
        n_pos   = r_pos + 3'd1;
        n_chars = r_chars;
        n_pad   = r_pad || is_pad;
        n_err   = r_err;
        n_late  = r_late;
        if (!is_pad) begin
            if (!sym.ok) begin
                n_err = 1'b1;
            end
            if (r_pad) begin
                n_late = 1'b1;
                n_err  = 1'b1;
            end else if (r_chars < FULL_CHARS) begin
                n_chars = r_chars + 4'd1;
            end
        end
    end

    assign tbl_count = bytes_for_count(n_chars);

    always_comb begin
        o_group.bits = n_bits;
        if (tbl_count == 3'd0 || n_late) begin
            o_group.count = MAX_BYTES;
            o_group.err   = 1'b1;
        end else begin
            o_group.count = tbl_count;
            o_group.err   = n_err;
        end
    end

    assign o_push = accept && (r_pos == LAST_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_pos   <= '0;
            r_chars <= '0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
            r_late  <= 1'b0;
        end else if (accept) begin
            if (r_pos == LAST_POS) begin
                r_bits  <= '0;
                r_pos   <= '0;
                r_chars <= '0;
                r_pad   <= 1'b0;
                r_err   <= 1'b0;
                r_late  <= 1'b0;
            end else begin
                r_bits  <= n_bits;
                r_pos   <= n_pos;
                r_chars <= n_chars;
                r_pad   <= n_pad;
                r_err   <= n_err;
                r_late  <= n_late;
            end
        end
    end

endmodule

@@ rtl/b32d_queue.sv @@
// ----------------------------------------------------------------------------
// b32d_queue
// Two-entry queue of finished groups between the front and the back.
// ----------------------------------------------------------------------------
module b32d_queue
    import b32d_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_group o_head
);

    t_group r_mem [QUEUE_DEPTH];
    logic   r_wr_ptr;
    logic   r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'(QUEUE_DEPTH));
    assign o_empty = (r_fill == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ rtl/b32d_back.sv @@
// ----------------------------------------------------------------------------
// b32d_back
// Walks the group at the head of the queue into the output register, most
// significant byte first, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module b32d_back
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_group     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_group_last,
    output logic       o_bad_input
);

    logic               r_valid;
    logic [7:0]         r_byte;
    logic               r_last;
    logic               r_err;
    logic [BYTES_W-1:0] r_idx;

    logic               advance;
    logic               take;
    logic               last;
    logic [7:0]         sel_byte;

    assign advance = !r_valid || !i_stall;
    assign take    = advance && !i_empty;
    assign last    = (r_idx == (i_head.count - 3'd1));
    assign o_pop   = take && last;

    always_comb begin
        case (r_idx)
            3'd0:    sel_byte = i_head.bits[39:32];
            3'd1:    sel_byte = i_head.bits[31:24];
            3'd2:    sel_byte = i_head.bits[23:16];
            3'd3:    sel_byte = i_head.bits[15:8];
            default: sel_byte = i_head.bits[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= last ? '0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= sel_byte;
            r_last <= last;
            r_err  <= i_head.err;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_byte  = r_byte;
    assign o_group_last = r_last;
    assign o_bad_input  = r_err;

endmodule

@@ rtl/base32_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base32_stream_decoder
// Streaming Base32 decoder: eight characters in, up to five bytes out.
// ----------------------------------------------------------------------------
// Input channel: one character per request on i_in_valid / o_in_stall.
// Output channel: one byte per request on o_out_valid / i_out_stall, with
// o_group_last on the final byte of a group and o_bad_input on every byte of
// a group that held a bad character or a bad padding layout.
// A character is taken every cycle unless the front stalls, which happens
// only on a group's eighth character while the two-entry group queue is full.
// The eighth character writes its group into the queue; the first byte is
// then loaded from the queue head into the output register; the remaining
// bytes follow one per cycle unless the output stalls. A group drains as
// the next arrives: with no output stall, one character enters per cycle.
// Reset clears the partial group, the queue and the output register.
// When the receiver stalls, the output byte holds; the queue absorbs up to
// two finished groups before the input channel stalls.
// ----------------------------------------------------------------------------
module base32_stream_decoder
    import b32d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_byte,
    output logic       o_group_last,
    output logic       o_bad_input
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_group grp_in;
    t_group grp_head;

    b32d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_char_code (i_char_code),
        .i_full      (full),
        .o_push      (push),
        .o_group     (grp_in)
    );

    b32d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (grp_head)
    );

    b32d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (grp_head),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_data_byte  (o_data_byte),
        .o_group_last (o_group_last),
        .o_bad_input  (o_bad_input)
    );

endmodule

@@ rtl/b32d_checker.sv @@
// ----------------------------------------------------------------------------
// b32d_checker
// Port-level checks of the Base32 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b32d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_char_code,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_data_byte,
    input logic       o_group_last,
    input logic       o_bad_input
);

    // A stalled output request stays up.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped while stalled");

    // A stalled output request keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_data_byte) && $stable(o_group_last) && $stable(o_bad_input))
        else $error("output payload changed while stalled");

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The error flag is the same on every byte of one group.
    a_err_per_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_group_last |=>
            !o_out_valid || (o_bad_input == $past(o_bad_input)))
        else $error("error flag changed within a group");

    // The input stalls only when the queue is full, and a full queue always
    // has a byte waiting at the output.
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output pending");

endmodule

bind base32_stream_decoder b32d_checker u_b32d_checker (.*);

@@ tb/base32_stream_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// base32_stream_decoder_tb
// Drives Base32 characters into the decoder, predicts every decoded byte from
// a behavioral model of the group logic, and compares each byte taken from the
// output channel with the oldest prediction, under varying sender gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module base32_stream_decoder_tb;
    import b32d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_byte_exp;

    typedef enum {GK_CLEAN, GK_BAD_COUNT, GK_BAD_CHAR, GK_LATE_DATA, GK_NOISE} t_group_kind;

    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 16;

    // Behavioral model of the group accumulator and the store of bytes due.
    class decoded_byte_board;
        logic [39:0] group_bits;
        logic [2:0]  char_pos;
        logic [3:0]  data_chars;
        logic        pad_seen;
        logic        group_err;
        logic        late_data;
        t_byte_exp   due_bytes[$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear_group();
        endfunction

        function void clear_group();
            group_bits = '0;
            char_pos   = '0;
            data_chars = '0;
            pad_seen   = 1'b0;
            group_err  = 1'b0;
            late_data  = 1'b0;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void take_char(logic [7:0] c);
            logic [7:0] diff;
            logic [4:0] sym;
            int         n_bytes;
            logic       err;
            t_byte_exp  e;
            sym = '0;
            if (c == CHAR_PAD) begin
                pad_seen = 1'b1;
            end else begin
                if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
                    diff = c - CHAR_UPPER_A;
                    sym  = diff[4:0];
                end else if (c >= CHAR_DIGIT_2 && c <= CHAR_DIGIT_7) begin
                    diff = c - CHAR_DIGIT_2 + DIGIT_BASE;
                    sym  = diff[4:0];
                end else begin
                    group_err = 1'b1;
                end
                if (pad_seen) begin
                    late_data = 1'b1;
                    group_err = 1'b1;
                end else if (data_chars < 4'd8) begin
                    data_chars = data_chars + 4'd1;
                end
            end
            group_bits = {group_bits[34:0], sym};
            char_pos   = char_pos + 3'd1;
            if (char_pos != 3'd0) return;

            case (data_chars)
                4'd2:    n_bytes = 1;
                4'd4:    n_bytes = 2;
                4'd5:    n_bytes = 3;
                4'd7:    n_bytes = 4;
                4'd8:    n_bytes = 5;
                default: n_bytes = 0;
            endcase
            err = group_err;
            // A broken padding layout or data after padding dumps all five bytes.
            if (n_bytes == 0 || late_data) begin
                err     = 1'b1;
                n_bytes = 5;
            end
            for (int k = 0; k < n_bytes; k++) begin
                e.data = group_bits[39 - 8 * k -: 8];
                e.last = (k == n_bytes - 1);
                e.bad  = err;
                due_bytes.push_back(e);
            end
            clear_group();
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic bad);
            t_byte_exp e;
            if (due_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected byte %h last %b bad %b", $realtime, data, last,
                             bad);
                return;
            end
            e = due_bytes.pop_front();
            if (data !== e.data || last !== e.last || bad !== e.bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected byte %h last %b bad %b, got byte %h last %b bad %b",
                             $realtime, e.data, e.last, e.bad, data, last, bad);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_char_code;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_data_byte;
    logic       o_group_last;
    logic       o_bad_input;

    decoded_byte_board board = new();

    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;

    base32_stream_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_byte (o_data_byte),
        .o_group_last(o_group_last),
        .o_bad_input (o_bad_input)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_byte(o_data_byte, o_group_last, o_bad_input);
    end

    function automatic logic [7:0] alpha_char();
        int unsigned v;
        v = $urandom_range(0, 31);
        return (v < 26) ? CHAR_UPPER_A + 8'(v) : CHAR_DIGIT_2 + 8'(v - 26);
    endfunction

    // Any code that is neither a symbol nor padding.
    function automatic logic [7:0] odd_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                   (c >= CHAR_DIGIT_2 && c <= CHAR_DIGIT_7) || c == CHAR_PAD);
        return c;
    endfunction

    function automatic t_group_kind pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return GK_CLEAN;
        if (r < 67) return GK_BAD_COUNT;
        if (r < 79) return GK_BAD_CHAR;
        if (r < 89) return GK_LATE_DATA;
        return GK_NOISE;
    endfunction

    // Eight characters, first character in the top byte.
    function automatic logic [63:0] random_group();
        int unsigned good_n [5] = '{2, 4, 5, 7, 8};
        int unsigned bad_n  [4] = '{0, 1, 3, 6};
        logic [7:0]  g [8];
        logic [63:0] w;
        t_group_kind kind;
        int unsigned n;
        int unsigned p;
        int          i;
        kind = pick_kind();
        case (kind)
            GK_BAD_COUNT: n = bad_n[$urandom_range(0, 3)];
            GK_LATE_DATA: n = $urandom_range(0, 6);
            default:      n = good_n[$urandom_range(0, 4)];
        endcase
        for (i = 0; i < 8; i++)
            g[i] = (i < n) ? alpha_char() : CHAR_PAD;
        case (kind)
            GK_BAD_CHAR: begin
                g[$urandom_range(0, n - 1)] = odd_char();
            end
            GK_LATE_DATA: begin
                p    = $urandom_range(n + 1, 7);
                g[p] = ($urandom_range(0, 3) == 0) ? odd_char() : alpha_char();
            end
            GK_NOISE: begin
                for (i = 0; i < 8; i++)
                    g[i] = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
        w = '0;
        for (i = 0; i < 8; i++)
            w = {w[55:0], g[i]};
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_char(c);
        @(negedge i_clk);
    endtask

    task automatic send_group(input logic [63:0] w);
        for (int i = 0; i < 8; i++)
            send_char(w[63 - 8 * i -: 8]);
    endtask

    // Sender goes quiet until every predicted byte has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic start_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                               input bit hold);
        @(posedge i_clk);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        hold_req      = hold;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_code = '0;
        i_out_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full group, a one-byte group, and a group with bad codes and late data.
        send_group("MZXW6YT7");
        send_group("GE======");
        send_group({8'h00, "Z=B", 8'hFF, "==="});
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       start_phase(0, 0, 1'b0);
                1:       start_phase(74, 0, 1'b0);
                2:       start_phase(0, 74, 1'b0);
                3:       start_phase(37, 37, 1'b0);
                default: start_phase(0, 0, 1'b1);
            endcase
            for (int g = 0; g < 3; g++)
                send_group(random_group());
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** base32_stream_decoder: PASSED **");
        end else begin
            $display("** base32_stream_decoder: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** base32_stream_decoder: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
rtl/b32d_pkg.sv
rtl/b32d_front.sv
rtl/b32d_queue.sv
rtl/b32d_back.sv
rtl/base32_stream_decoder.sv
rtl/b32d_checker.sv
tb/base32_stream_decoder_tb.sv
